### rtl/core/vector2_rotate_degrees_defines.svh
// -----------------------------------------------------------------------------
// vector2_rotate_degrees_defines
// Assertion macros for the checker file of the vector rotator.
// -----------------------------------------------------------------------------
`ifndef VECTOR2_ROTATE_DEGREES_DEFINES_SVH
`define VECTOR2_ROTATE_DEGREES_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define V2RD_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("v2rd assertion failed");

// Next-cycle implication, off while reset is held.
`define V2RD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("v2rd assertion failed");

// Next-cycle implication that also watches the reset cycles.
`define V2RD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("v2rd assertion failed");

`endif

### rtl/core/v2rd_pkg.sv
// -----------------------------------------------------------------------------
// v2rd_pkg
// Shared types and constants of the CORDIC vector rotator.
// -----------------------------------------------------------------------------
package v2rd_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int PHASE_WIDTH = 32;
    localparam int GUARD_BITS  = 16;
    localparam int TABLE_LEN   = 32;

    // Angle reduction in 1/64 degree units, one bit wider than the input
    localparam logic signed [ANGLE_WIDTH:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [ANGLE_WIDTH:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [ANGLE_WIDTH:0] QUARTER_TURN = 17'sd5760;
    localparam int MAG_WIDTH = 13;

    // phase = round(a * 2^23 / 45) = a * 186413 + floor((23 * a + 22) / 45)
    localparam int PROD_WIDTH  = 31;
    localparam int REM_WIDTH   = 18;
    localparam int RECIP_SHIFT = 24;
    localparam int QUO_WIDTH   = REM_WIDTH + 19;
    localparam logic [PROD_WIDTH-1:0] PHASE_MUL  = 31'd186413;
    localparam logic [REM_WIDTH-1:0]  PHASE_REM  = 18'd23;
    localparam logic [REM_WIDTH-1:0]  PHASE_BIAS = 18'd22;
    localparam logic [QUO_WIDTH-1:0]  RECIP_45   = 37'd372828;

    // Gain compensation, K in Q30
    localparam int GAIN_FRAC  = 30;
    localparam int GAIN_WIDTH = 31;
    localparam int GAIN_SPLIT = 17;
    localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q30 = 31'sd652032874;

    // atan(2^-i) in phase units, 2^32 per turn
    localparam logic [PHASE_WIDTH-1:0] ATAN_PHASE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic valid;
        logic zero_ang;
    } ctl_t;

endpackage

### rtl/core/vector2_rotate_degrees.sv
// -----------------------------------------------------------------------------
// vector2_rotate_degrees
// Pipelined, gain-compensated CORDIC rotation of a 2D vector by an angle.
// -----------------------------------------------------------------------------
// Usage:
//   Input beat (s_valid/s_ready): s_x_in, s_y_in signed coordinates and
//   s_angle_inc, the rotation in 1/64 degree, counterclockwise positive.
//   Any 16-bit angle is reduced modulo one turn.
//   Output beat (m_valid/m_ready): m_x_out, m_y_out, the rotated vector,
//   one bit wider than the input. One output beat follows each input beat,
//   in order.
//   Pipeline: CORDIC_STAGES + 5 register stages from input beat to m_valid
//   (21 at the default), with CORDIC_STAGES capped at 32. Three stages reduce
//   the angle and form the phase, one stage per micro-rotation, two for gain
//   and rounding.
//   Throughput: one beat per cycle unless m_ready stalls. Every stage has
//   its own valid bit and loads when empty or when its successor moves, so
//   bubbles close up in a stall; s_ready drops only once the pipeline is full.
//   Reset clears all valid bits; the block takes a beat on the next cycle.
// -----------------------------------------------------------------------------
module vector2_rotate_degrees #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [COORD_WIDTH-1:0]           s_x_in,
    input  logic signed [COORD_WIDTH-1:0]           s_y_in,
    input  logic signed [v2rd_pkg::ANGLE_WIDTH-1:0] s_angle_inc,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [COORD_WIDTH:0]             m_x_out,
    output logic signed [COORD_WIDTH:0]             m_y_out
);

    localparam int NUM_ITER  = (CORDIC_STAGES > v2rd_pkg::TABLE_LEN) ?
                               v2rd_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int VEC_WIDTH = COORD_WIDTH + 1;
    localparam int ACC_WIDTH = VEC_WIDTH + 2 + v2rd_pkg::GUARD_BITS;
    localparam int AW        = v2rd_pkg::ANGLE_WIDTH;
    localparam int MW        = v2rd_pkg::MAG_WIDTH;
    localparam int PW        = v2rd_pkg::PHASE_WIDTH;

    // ---------------- stage 1: turn reduction and half-turn fold ----------------
    logic signed [AW:0]        ang_wide, ang_turn, ang_fold, ang_abs;
    logic                      flip;
    logic signed [VEC_WIDTH-1:0] x_wide, y_wide;

    v2rd_pkg::ctl_t              st1_ctl_reg, st1_ctl_next;
    logic signed [VEC_WIDTH-1:0] st1_x_reg, st1_x_next, st1_y_reg, st1_y_next;
    logic [MW-1:0]               st1_mag_reg, st1_mag_next;
    logic                        st1_neg_reg;
    logic                        st1_ready;

    always_comb begin
        ang_wide = signed'({s_angle_inc[AW-1], s_angle_inc});
        priority if (ang_wide > v2rd_pkg::HALF_TURN) begin
            ang_turn = ang_wide - v2rd_pkg::FULL_TURN;
        end else if (ang_wide <= -v2rd_pkg::HALF_TURN) begin
            ang_turn = ang_wide + v2rd_pkg::FULL_TURN;
        end else begin
            ang_turn = ang_wide;
        end

        // past a quarter turn: negate the vector, move the angle by a half turn
        priority if (ang_turn > v2rd_pkg::QUARTER_TURN) begin
            flip     = 1'b1;
            ang_fold = ang_turn - v2rd_pkg::HALF_TURN;
        end else if (ang_turn < -v2rd_pkg::QUARTER_TURN) begin
            flip     = 1'b1;
            ang_fold = ang_turn + v2rd_pkg::HALF_TURN;
        end else begin
            flip     = 1'b0;
            ang_fold = ang_turn;
        end

        ang_abs = ang_fold[AW] ? -ang_fold : ang_fold;
        x_wide  = signed'({s_x_in[COORD_WIDTH-1], s_x_in});
        y_wide  = signed'({s_y_in[COORD_WIDTH-1], s_y_in});

        st1_x_next            = flip ? -x_wide : x_wide;
        st1_y_next            = flip ? -y_wide : y_wide;
        st1_mag_next          = ang_abs[MW-1:0];
        st1_ctl_next.valid    = s_valid;
        st1_ctl_next.zero_ang = (ang_fold == '0);
    end

    // ---------------- stage 2: phase products ----------------
    v2rd_pkg::ctl_t                       st2_ctl_reg;
    logic signed [VEC_WIDTH-1:0]          st2_x_reg, st2_y_reg;
    logic [v2rd_pkg::PROD_WIDTH-1:0]      st2_prod_reg, st2_prod_next;
    logic [v2rd_pkg::REM_WIDTH-1:0]       st2_rem_reg, st2_rem_next;
    logic                                 st2_neg_reg;
    logic                                 st2_ready;

    always_comb begin
        st2_prod_next = v2rd_pkg::PROD_WIDTH'(st1_mag_reg) * v2rd_pkg::PHASE_MUL;
        st2_rem_next  = v2rd_pkg::REM_WIDTH'(st1_mag_reg) * v2rd_pkg::PHASE_REM
                        + v2rd_pkg::PHASE_BIAS;
    end

    // ---------------- stage 3: divide remainder by 45, signed phase ----------------
    logic [v2rd_pkg::QUO_WIDTH-1:0]   quo_prod;
    logic [MW-1:0]                    quo;
    logic [v2rd_pkg::PROD_WIDTH-1:0]  phase_mag;
    logic signed [PW-1:0]             phase_s;

    v2rd_pkg::ctl_t              st3_ctl_reg;
    logic signed [ACC_WIDTH-1:0] st3_x_reg, st3_x_next, st3_y_reg, st3_y_next;
    logic signed [PW-1:0]        st3_z_reg, st3_z_next;
    logic                        st3_ready;

    always_comb begin
        quo_prod   = v2rd_pkg::QUO_WIDTH'(st2_rem_reg) * v2rd_pkg::RECIP_45;
        quo        = quo_prod[v2rd_pkg::RECIP_SHIFT +: MW];
        phase_mag  = st2_prod_reg + v2rd_pkg::PROD_WIDTH'(quo);
        phase_s    = signed'({1'b0, phase_mag});
        st3_z_next = st2_neg_reg ? -phase_s : phase_s;
        st3_x_next = {{(ACC_WIDTH-VEC_WIDTH-v2rd_pkg::GUARD_BITS){st2_x_reg[VEC_WIDTH-1]}},
                      st2_x_reg, {v2rd_pkg::GUARD_BITS{1'b0}}};
        st3_y_next = {{(ACC_WIDTH-VEC_WIDTH-v2rd_pkg::GUARD_BITS){st2_y_reg[VEC_WIDTH-1]}},
                      st2_y_reg, {v2rd_pkg::GUARD_BITS{1'b0}}};
    end

    // ---------------- front-end registers ----------------
    v2rd_pkg::ctl_t              cor_ctl   [0:NUM_ITER];
    logic signed [ACC_WIDTH-1:0] cor_x     [0:NUM_ITER];
    logic signed [ACC_WIDTH-1:0] cor_y     [0:NUM_ITER];
    logic signed [PW-1:0]        cor_z     [0:NUM_ITER-1];
    logic                        cor_ready [0:NUM_ITER];

    assign st3_ready = !st3_ctl_reg.valid || cor_ready[0];
    assign st2_ready = !st2_ctl_reg.valid || st3_ready;
    assign st1_ready = !st1_ctl_reg.valid || st2_ready;
    assign s_ready   = st1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_ctl_reg <= '0;
            st2_ctl_reg <= '0;
            st3_ctl_reg <= '0;
        end else begin
            if (st1_ready) begin
                st1_ctl_reg <= st1_ctl_next;
            end
            if (st2_ready) begin
                st2_ctl_reg <= st1_ctl_reg;
            end
            if (st3_ready) begin
                st3_ctl_reg <= st2_ctl_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            st1_x_reg   <= st1_x_next;
            st1_y_reg   <= st1_y_next;
            st1_mag_reg <= st1_mag_next;
            st1_neg_reg <= ang_fold[AW];
        end
        if (st2_ready) begin
            st2_x_reg    <= st1_x_reg;
            st2_y_reg    <= st1_y_reg;
            st2_prod_reg <= st2_prod_next;
            st2_rem_reg  <= st2_rem_next;
            st2_neg_reg  <= st1_neg_reg;
        end
        if (st3_ready) begin
            st3_x_reg <= st3_x_next;
            st3_y_reg <= st3_y_next;
            st3_z_reg <= st3_z_next;
        end
    end

    // ---------------- micro-rotation pipeline ----------------
    assign cor_ctl[0] = st3_ctl_reg;
    assign cor_x[0]   = st3_x_reg;
    assign cor_y[0]   = st3_y_reg;
    assign cor_z[0]   = st3_z_reg;

    for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
        if (k < NUM_ITER - 1) begin : g_mid
            v2rd_cordic_stage #(
                .ACC_WIDTH (ACC_WIDTH),
                .STEP      (k)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_ctl    (cor_ctl[k]),
                .in_x      (cor_x[k]),
                .in_y      (cor_y[k]),
                .in_z      (cor_z[k]),
                .in_ready  (cor_ready[k]),
                .out_ctl   (cor_ctl[k+1]),
                .out_x     (cor_x[k+1]),
                .out_y     (cor_y[k+1]),
                .out_z     (cor_z[k+1]),
                .out_ready (cor_ready[k+1])
            );
        end else begin : g_last
            // the phase is spent after the last micro-rotation
            v2rd_cordic_stage #(
                .ACC_WIDTH (ACC_WIDTH),
                .STEP      (k)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_ctl    (cor_ctl[k]),
                .in_x      (cor_x[k]),
                .in_y      (cor_y[k]),
                .in_z      (cor_z[k]),
                .in_ready  (cor_ready[k]),
                .out_ctl   (cor_ctl[k+1]),
                .out_x     (cor_x[k+1]),
                .out_y     (cor_y[k+1]),
                .out_z     (),
                .out_ready (cor_ready[k+1])
            );
        end
    end

    // ---------------- gain, rounding and output register ----------------
    v2rd_gain #(
        .COORD_WIDTH (COORD_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (cor_ctl[NUM_ITER]),
        .in_x      (cor_x[NUM_ITER]),
        .in_y      (cor_y[NUM_ITER]),
        .in_ready  (cor_ready[NUM_ITER]),
        .out_valid (m_valid),
        .out_x     (m_x_out),
        .out_y     (m_y_out),
        .out_ready (m_ready)
    );

endmodule

### rtl/core/v2rd_cordic_stage.sv
// -----------------------------------------------------------------------------
// v2rd_cordic_stage
// One registered CORDIC micro-rotation with its own valid and ready.
// -----------------------------------------------------------------------------
module v2rd_cordic_stage #(
    parameter int ACC_WIDTH = 35,
    parameter int STEP      = 0
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  v2rd_pkg::ctl_t                            in_ctl,
    input  logic signed [ACC_WIDTH-1:0]               in_x,
    input  logic signed [ACC_WIDTH-1:0]               in_y,
    input  logic signed [v2rd_pkg::PHASE_WIDTH-1:0]   in_z,
    output logic                                      in_ready,
    output v2rd_pkg::ctl_t                            out_ctl,
    output logic signed [ACC_WIDTH-1:0]               out_x,
    output logic signed [ACC_WIDTH-1:0]               out_y,
    output logic signed [v2rd_pkg::PHASE_WIDTH-1:0]   out_z,
    input  logic                                      out_ready
);

    localparam logic signed [v2rd_pkg::PHASE_WIDTH-1:0] ATAN =
        signed'(v2rd_pkg::ATAN_PHASE[STEP]);

    v2rd_pkg::ctl_t                          ctl_reg;
    logic signed [ACC_WIDTH-1:0]             x_reg, x_next;
    logic signed [ACC_WIDTH-1:0]             y_reg, y_next;
    logic signed [v2rd_pkg::PHASE_WIDTH-1:0] z_reg, z_next;
    logic signed [ACC_WIDTH-1:0]             x_shift, y_shift;

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb begin
        x_shift = in_x >>> STEP;
        y_shift = in_y >>> STEP;
        x_next  = in_x;
        y_next  = in_y;
        z_next  = in_z;
        // zero folded input angle: carry the vector through untouched
        if (!in_ctl.zero_ang) begin
            if (!in_z[v2rd_pkg::PHASE_WIDTH-1]) begin
                x_next = in_x - y_shift;
                y_next = in_y + x_shift;
                z_next = in_z - ATAN;
            end else begin
                x_next = in_x + y_shift;
                y_next = in_y - x_shift;
                z_next = in_z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (in_ready) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_z   = z_reg;

endmodule

### rtl/core/v2rd_gain.sv
// -----------------------------------------------------------------------------
// v2rd_gain
// Two-stage gain compensation and rounding; the second stage is the output.
// -----------------------------------------------------------------------------
module v2rd_gain #(
    parameter int COORD_WIDTH = 16,
    parameter int ACC_WIDTH   = 35
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  v2rd_pkg::ctl_t              in_ctl,
    input  logic signed [ACC_WIDTH-1:0] in_x,
    input  logic signed [ACC_WIDTH-1:0] in_y,
    output logic                        in_ready,
    output logic                        out_valid,
    output logic signed [COORD_WIDTH:0] out_x,
    output logic signed [COORD_WIDTH:0] out_y,
    input  logic                        out_ready
);

    localparam int OUT_WIDTH   = COORD_WIDTH + 1;
    localparam int LO_WIDTH    = v2rd_pkg::GAIN_SPLIT;
    localparam int HI_WIDTH    = ACC_WIDTH - LO_WIDTH;
    localparam int PLO_WIDTH   = LO_WIDTH + 1 + v2rd_pkg::GAIN_WIDTH;
    localparam int PHI_WIDTH   = HI_WIDTH + v2rd_pkg::GAIN_WIDTH;
    localparam int SUM_WIDTH   = ACC_WIDTH + v2rd_pkg::GAIN_WIDTH;
    localparam int ROUND_SHIFT = v2rd_pkg::GAIN_FRAC + v2rd_pkg::GUARD_BITS;
    localparam logic signed [SUM_WIDTH-1:0] ROUND_BIAS =
        {{(SUM_WIDTH-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}};

    logic                          g1_valid_reg;
    logic                          g1_zero_reg;
    logic signed [PLO_WIDTH-1:0]   plo_x_reg, plo_y_reg, plo_x_next, plo_y_next;
    logic signed [PHI_WIDTH-1:0]   phi_x_reg, phi_y_reg, phi_x_next, phi_y_next;
    logic signed [OUT_WIDTH-1:0]   byp_x_reg, byp_y_reg;
    logic signed [LO_WIDTH:0]      lo_x, lo_y;
    logic signed [HI_WIDTH-1:0]    hi_x, hi_y;
    logic signed [SUM_WIDTH-1:0]   sum_x, sum_y;
    logic                          out_valid_reg;
    logic signed [OUT_WIDTH-1:0]   out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic                          g2_ready;

    assign g2_ready = !out_valid_reg || out_ready;
    assign in_ready = !g1_valid_reg || g2_ready;

    // split each coordinate so no single product exceeds the multiplier size
    always_comb begin
        lo_x       = signed'({1'b0, in_x[LO_WIDTH-1:0]});
        lo_y       = signed'({1'b0, in_y[LO_WIDTH-1:0]});
        hi_x       = signed'(in_x[ACC_WIDTH-1:LO_WIDTH]);
        hi_y       = signed'(in_y[ACC_WIDTH-1:LO_WIDTH]);
        plo_x_next = lo_x * v2rd_pkg::GAIN_Q30;
        plo_y_next = lo_y * v2rd_pkg::GAIN_Q30;
        phi_x_next = hi_x * v2rd_pkg::GAIN_Q30;
        phi_y_next = hi_y * v2rd_pkg::GAIN_Q30;
    end

    // recombine, round half up, drop guard and gain fraction bits; a zero angle bypasses the gain
    always_comb begin
        sum_x = (SUM_WIDTH'(phi_x_reg) <<< LO_WIDTH) + SUM_WIDTH'(plo_x_reg) + ROUND_BIAS;
        sum_y = (SUM_WIDTH'(phi_y_reg) <<< LO_WIDTH) + SUM_WIDTH'(plo_y_reg) + ROUND_BIAS;
        if (g1_zero_reg) begin
            out_x_next = byp_x_reg;
            out_y_next = byp_y_reg;
        end else begin
            out_x_next = sum_x[ROUND_SHIFT +: OUT_WIDTH];
            out_y_next = sum_y[ROUND_SHIFT +: OUT_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                g1_valid_reg <= in_ctl.valid;
            end
            if (g2_ready) begin
                out_valid_reg <= g1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            g1_zero_reg <= in_ctl.zero_ang;
            plo_x_reg   <= plo_x_next;
            plo_y_reg   <= plo_y_next;
            phi_x_reg   <= phi_x_next;
            phi_y_reg   <= phi_y_next;
            byp_x_reg   <= in_x[v2rd_pkg::GUARD_BITS +: OUT_WIDTH];
            byp_y_reg   <= in_y[v2rd_pkg::GUARD_BITS +: OUT_WIDTH];
        end
        if (g2_ready) begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

endmodule

### rtl/core/v2rd_checker.sv
// -----------------------------------------------------------------------------
// v2rd_checker
// Port-level checks of the vector rotator, bound to the top level.
// -----------------------------------------------------------------------------
`include "vector2_rotate_degrees_defines.svh"

module v2rd_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [COORD_WIDTH:0] m_x_out,
    input logic signed [COORD_WIDTH:0] m_y_out
);

    logic out_stall;

    assign out_stall = m_valid && !m_ready;

    // a stalled result beat holds
    `V2RD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable({m_x_out, m_y_out}))

    // with the output draining, every stage can move, so input is taken
    `V2RD_ASSERT(a_ready_when_draining, aclk, aresetn, m_ready || !m_valid, s_ready)

    // reset empties the pipeline
    `V2RD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind vector2_rotate_degrees v2rd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_v2rd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_x_out (m_x_out),
    .m_y_out (m_y_out)
);
